// ----- rtl/tep_pkg.sv -----
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types and constants of the terminal escape parser.
// ----------------------------------------------------------------------------
package tep_pkg;

   localparam int MAX_PARAMS = 16;
   localparam int PIDX_W     = $clog2(MAX_PARAMS);
   localparam int PCNT_W     = $clog2(MAX_PARAMS + 1);
   localparam int TAB_WIDTH  = 8;

   // stream bytes
   localparam logic [7:0] B_ESC   = 8'h1B;
   localparam logic [7:0] B_BEL   = 8'h07;
   localparam logic [7:0] B_BS    = 8'h08;
   localparam logic [7:0] B_TAB   = 8'h09;
   localparam logic [7:0] B_LF    = 8'h0A;
   localparam logic [7:0] B_VT    = 8'h0B;
   localparam logic [7:0] B_FF    = 8'h0C;
   localparam logic [7:0] B_CR    = 8'h0D;
   localparam logic [7:0] B_SPACE = 8'h20;
   localparam logic [7:0] B_ZERO  = 8'h30;
   localparam logic [7:0] B_NINE  = 8'h39;
   localparam logic [7:0] B_SEMI  = 8'h3B;
   localparam logic [7:0] B_QUERY = 8'h3F;
   localparam logic [7:0] B_FIN_LO = 8'h40;
   localparam logic [7:0] B_FIN_HI = 8'h7E;
   localparam logic [7:0] B_LBRACK = 8'h5B;
   localparam logic [7:0] B_RBRACK = 8'h5D;
   localparam logic [7:0] B_DCS   = 8'h50;
   localparam logic [7:0] B_BSLASH = 8'h5C;
   localparam logic [7:0] F_CUU   = 8'h41;
   localparam logic [7:0] F_CUD   = 8'h42;
   localparam logic [7:0] F_CUF   = 8'h43;
   localparam logic [7:0] F_CUB   = 8'h44;
   localparam logic [7:0] F_CUP   = 8'h48;
   localparam logic [7:0] F_HVP   = 8'h66;
   localparam logic [7:0] F_ED    = 8'h4A;
   localparam logic [7:0] F_EL    = 8'h4B;
   localparam logic [7:0] F_SGR   = 8'h6D;
   localparam logic [7:0] F_SM    = 8'h68;
   localparam logic [7:0] F_RM    = 8'h6C;
   localparam logic [7:0] F_SCP   = 8'h73;
   localparam logic [7:0] F_RCP   = 8'h75;

   localparam logic [4:0] COLOUR_DEFAULT = 5'd16;

   // configuration register indexes
   localparam logic [2:0] CSR_ROWS   = 3'd0;
   localparam logic [2:0] CSR_COLS   = 3'd1;
   localparam logic [2:0] CSR_TOP    = 3'd2;
   localparam logic [2:0] CSR_BOTTOM = 3'd3;
   localparam logic [2:0] CSR_WRAP   = 3'd4;

   typedef enum logic [2:0] {
      PM_NORMAL, PM_ESCAPE, PM_CSI, PM_OSC, PM_DCS
   } parse_mode_type;

   typedef enum logic [2:0] {
      CMD_GLYPH, CMD_CLEAR_LINE, CMD_SCROLL, CMD_CLEAR_SCREEN,
      CMD_DIRTY, CMD_SET_MODE, CMD_RESET_MODE
   } grid_cmd_type;

   typedef enum logic [2:0] {
      CLS_NONE, CLS_NEWLINE, CLS_GLYPH, CLS_SINGLE, CLS_SGR
   } byte_class_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LATCH, OP_DECODE, OP_GLYPH, OP_CLAMP, OP_DIRTY_HOME,
      OP_LINE_DOWN, OP_DIRTY, OP_CLEAR, OP_SINGLE, OP_SGR_STEP
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_GLYPH, ST_WRAP, ST_DIRTY_HOME, ST_LD_WRAP,
      ST_DIRTY_MID, ST_DIRTY_LAST, ST_CLEAR, ST_LD_NL, ST_SINGLE, ST_SGR
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] rows;
      logic [7:0] cols;
      logic [7:0] top;
      logic [7:0] bottom;
      logic       wrap;
   } cfg_type;

   typedef struct packed {
      dp_op_type op;
      logic      last;
   } ctrl_cmd_type;

   typedef struct packed {
      byte_class_type cls;
      logic           fits;
      logic           x_past;
      logic           wrap_en;
      logic           sgr_done;
      logic           out_free;
   } dp_status_type;

endpackage

// ----- rtl/tep_req_if.sv -----
// ----------------------------------------------------------------------------
// tep_req_if
// Byte channel into the parser.
// ----------------------------------------------------------------------------
interface tep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       chunk_last;

   modport source (output valid, in_byte, chunk_last, input ready);
   modport sink   (input valid, in_byte, chunk_last, output ready);
endinterface

// ----- rtl/tep_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tep_rsp_if
// Grid command channel out of the parser.
// ----------------------------------------------------------------------------
interface tep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  row;
   logic [7:0]  col;
   logic [20:0] codepoint;
   logic [4:0]  fg_code;
   logic [4:0]  bg_code;
   logic [2:0]  attr_bits;
   logic [15:0] mode_number;
   logic        last;

   modport source (output valid, cmd, row, col, codepoint, fg_code, bg_code,
                   attr_bits, mode_number, last, input ready);
   modport sink   (input valid, cmd, row, col, codepoint, fg_code, bg_code,
                   attr_bits, mode_number, last, output ready);
endinterface

// ----- rtl/tep_datapath.sv -----
// ----------------------------------------------------------------------------
// tep_datapath
// Parse state, cursor, parameters, UTF-8 decode, colours and result register.
// ----------------------------------------------------------------------------
module tep_datapath import tep_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  ctrl_cmd_type   cmd,
   input  logic [7:0]     in_byte,
   input  logic           chunk_last,
   input  logic           rsp_ready,
   output dp_status_type  status,
   output logic           rsp_valid,
   output logic [2:0]     rsp_cmd,
   output logic [7:0]     rsp_row,
   output logic [7:0]     rsp_col,
   output logic [20:0]    rsp_codepoint,
   output logic [4:0]     rsp_fg_code,
   output logic [4:0]     rsp_bg_code,
   output logic [2:0]     rsp_attr_bits,
   output logic [15:0]    rsp_mode_number,
   output logic           rsp_last
);

   parse_mode_type mode_ff, mode_in;
   logic        prev_esc_ff, prev_esc_in;
   logic [7:0]  x_ff, x_in, y_ff, y_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [15:0] store_ff [MAX_PARAMS];
   logic [15:0] store_in [MAX_PARAMS];
   logic [PCNT_W-1:0] total_ff, total_in;
   logic [15:0] acc_ff, acc_in;
   logic        priv_ff, priv_in;
   logic [1:0]  upend_ff, upend_in;
   logic [20:0] uacc_ff, uacc_in;
   logic [4:0]  fg_ff, fg_in, bg_ff, bg_in;
   logic [2:0]  attr_ff, attr_in;
   logic [7:0]  byte_ff, byte_in;
   logic        chunk_ff, chunk_in;
   logic [20:0] cp_ff, cp_in;
   logic [PIDX_W-1:0] sidx_ff, sidx_in;
   grid_cmd_type single_cmd_ff, single_cmd_in;
   logic [7:0]  single_row_ff, single_row_in;
   logic [15:0] single_mode_ff, single_mode_in;
   logic        ov_ff, ov_in;
   grid_cmd_type ocmd_ff, ocmd_in;
   logic [7:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic [20:0] ocp_ff, ocp_in;
   logic [4:0]  ofg_ff, ofg_in, obg_ff, obg_in;
   logic [2:0]  oattr_ff, oattr_in;
   logic [15:0] omode_ff, omode_in;
   logic        olast_ff, olast_in;

   logic [7:0]  rows_eff, cols_eff, rows_m1, cols_m1;
   logic [PCNT_W-1:0] teff, tm1;
   logic [PIDX_W-1:0] lastidx;
   logic [15:0] p0, p1, psgr, r16, c16;
   logic [19:0] acc_next;
   logic [8:0]  tab9;
   logic [3:0]  digit;
   byte_class_type cls;
   logic        out_free;

   assign rows_eff = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;
   assign cols_eff = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
   assign rows_m1  = rows_eff - 8'd1;
   assign cols_m1  = cols_eff - 8'd1;
   assign teff     = (total_ff == '0) ? PCNT_W'(1) : total_ff;
   assign tm1      = teff - PCNT_W'(1);
   assign lastidx  = tm1[PIDX_W-1:0];
   assign p0       = (lastidx == PIDX_W'(0)) ? acc_ff : store_ff[0];
   assign p1       = (lastidx == PIDX_W'(1)) ? acc_ff : store_ff[1];
   assign psgr     = (sidx_ff == lastidx) ? acc_ff : store_ff[sidx_ff];
   assign r16      = (p0 != 16'd0) ? p0 - 16'd1 : 16'd0;
   assign c16      = (teff > PCNT_W'(1) && p1 != 16'd0) ? p1 - 16'd1 : 16'd0;
   assign digit    = byte_ff[3:0];
   assign acc_next = {acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {16'd0, digit};
   assign tab9     = ({1'b0, x_ff} + 9'(TAB_WIDTH)) & ~9'(TAB_WIDTH - 1);
   assign out_free = !ov_ff || rsp_ready;

   // byte classification for the decode step
   always_comb begin
      cls = CLS_NONE;
      case (mode_ff)
         PM_NORMAL: begin
            if (byte_ff == B_LF || byte_ff == B_VT || byte_ff == B_FF) begin
               cls = CLS_NEWLINE;
            end else if (byte_ff >= B_SPACE && byte_ff != B_ESC) begin
               if (byte_ff[7:6] == 2'b10) begin
                  if (upend_ff == 2'd1) cls = CLS_GLYPH;
               end else if (!byte_ff[7] || byte_ff[7:3] == 5'b11111) begin
                  cls = CLS_GLYPH;
               end
            end
         end
         PM_CSI: begin
            if (byte_ff == F_ED || byte_ff == F_EL) begin
               cls = CLS_SINGLE;
            end else if ((byte_ff == F_SM || byte_ff == F_RM) && priv_ff) begin
               cls = CLS_SINGLE;
            end else if (byte_ff == F_SGR && p0 != 16'd0) begin
               cls = CLS_SGR;
            end
         end
         default: cls = CLS_NONE;
      endcase
   end

   always_comb begin
      mode_in = mode_ff; prev_esc_in = prev_esc_ff;
      x_in = x_ff; y_in = y_ff; sx_in = sx_ff; sy_in = sy_ff;
      store_in = store_ff; total_in = total_ff; acc_in = acc_ff; priv_in = priv_ff;
      upend_in = upend_ff; uacc_in = uacc_ff;
      fg_in = fg_ff; bg_in = bg_ff; attr_in = attr_ff;
      byte_in = byte_ff; chunk_in = chunk_ff; cp_in = cp_ff; sidx_in = sidx_ff;
      single_cmd_in = single_cmd_ff; single_row_in = single_row_ff;
      single_mode_in = single_mode_ff;
      ov_in = ov_ff && !rsp_ready;
      ocmd_in = ocmd_ff; orow_in = orow_ff; ocol_in = ocol_ff; ocp_in = ocp_ff;
      ofg_in = ofg_ff; obg_in = obg_ff; oattr_in = oattr_ff; omode_in = omode_ff;
      olast_in = olast_ff;
      case (cmd.op)
         OP_LATCH: begin
            byte_in = in_byte;
            chunk_in = chunk_last;
         end
         OP_DECODE: begin
            prev_esc_in = (byte_ff == B_ESC) && !chunk_ff;
            case (mode_ff)
               PM_NORMAL: begin
                  if (byte_ff == B_ESC) begin
                     mode_in = PM_ESCAPE;
                  end else if (byte_ff == B_CR) begin
                     x_in = 8'd0;
                  end else if (byte_ff == B_BS) begin
                     if (x_ff != 8'd0) x_in = x_ff - 8'd1;
                  end else if (byte_ff == B_TAB) begin
                     x_in = (tab9 >= {1'b0, cols_eff}) ? cols_m1 : tab9[7:0];
                  end else if (byte_ff >= B_SPACE) begin
                     if (byte_ff[7:6] == 2'b10) begin
                        if (upend_ff != 2'd0) begin
                           uacc_in  = {uacc_ff[14:0], byte_ff[5:0]};
                           upend_in = upend_ff - 2'd1;
                           cp_in    = {uacc_ff[14:0], byte_ff[5:0]};
                        end
                     end else if (!byte_ff[7]) begin
                        upend_in = 2'd0;
                        cp_in    = {13'd0, byte_ff};
                     end else if (byte_ff[7:5] == 3'b110) begin
                        uacc_in = {16'd0, byte_ff[4:0]}; upend_in = 2'd1;
                     end else if (byte_ff[7:4] == 4'b1110) begin
                        uacc_in = {17'd0, byte_ff[3:0]}; upend_in = 2'd2;
                     end else if (byte_ff[7:3] == 5'b11110) begin
                        uacc_in = {18'd0, byte_ff[2:0]}; upend_in = 2'd3;
                     end else begin
                        cp_in = {13'd0, byte_ff};
                     end
                  end
               end
               PM_ESCAPE: begin
                  if (byte_ff == B_LBRACK) begin
                     mode_in = PM_CSI;
                     total_in = '0;
                     acc_in = 16'd0;
                     priv_in = 1'b0;
                     for (int i = 0; i < MAX_PARAMS; i++) store_in[i] = 16'd0;
                  end else if (byte_ff == B_RBRACK) begin
                     mode_in = PM_OSC;
                  end else if (byte_ff == B_DCS) begin
                     mode_in = PM_DCS;
                  end else begin
                     mode_in = PM_NORMAL;
                  end
               end
               PM_CSI: begin
                  if (byte_ff == B_QUERY) begin
                     priv_in = 1'b1;
                  end else if (byte_ff >= B_ZERO && byte_ff <= B_NINE) begin
                     if (total_ff == '0) total_in = PCNT_W'(1);
                     acc_in = (acc_next > 20'd65535) ? 16'hFFFF : acc_next[15:0];
                  end else if (byte_ff == B_SEMI) begin
                     if (total_ff == '0) begin
                        total_in = PCNT_W'(2);
                        store_in[0] = acc_ff;
                        acc_in = 16'd0;
                     end else if (total_ff < PCNT_W'(MAX_PARAMS)) begin
                        store_in[lastidx] = acc_ff;
                        acc_in = 16'd0;
                        total_in = total_ff + PCNT_W'(1);
                     end
                  end else if (byte_ff >= B_FIN_LO && byte_ff <= B_FIN_HI) begin
                     mode_in = PM_NORMAL;
                     single_mode_in = p0;
                     single_row_in = 8'd0;
                     sidx_in = '0;
                     single_cmd_in = (byte_ff == F_SM) ? CMD_SET_MODE : CMD_RESET_MODE;
                     case (byte_ff)
                        F_CUU: if (y_ff != 8'd0) y_in = y_ff - 8'd1;
                        F_CUD: y_in = (y_ff < rows_m1) ? y_ff + 8'd1 : rows_m1;
                        F_CUF: x_in = (x_ff < cols_m1) ? x_ff + 8'd1 : cols_m1;
                        F_CUB: if (x_ff != 8'd0) x_in = x_ff - 8'd1;
                        F_CUP, F_HVP: begin
                           y_in = (r16 < {8'd0, rows_eff}) ? r16[7:0] : rows_m1;
                           x_in = (c16 < {8'd0, cols_eff}) ? c16[7:0] : cols_m1;
                        end
                        F_ED: single_cmd_in = CMD_CLEAR_SCREEN;
                        F_EL: begin
                           single_cmd_in = CMD_CLEAR_LINE;
                           single_row_in = y_ff;
                        end
                        F_SGR: begin
                           if (p0 == 16'd0) begin
                              fg_in = COLOUR_DEFAULT; bg_in = COLOUR_DEFAULT;
                              attr_in = 3'd0;
                           end
                        end
                        F_SCP: begin
                           sx_in = x_ff; sy_in = y_ff;
                        end
                        F_RCP: begin
                           x_in = sx_ff; y_in = sy_ff;
                        end
                        default: ;
                     endcase
                  end
               end
               PM_OSC, PM_DCS: begin
                  if (byte_ff == B_BEL || (byte_ff == B_BSLASH && prev_esc_ff))
                     mode_in = PM_NORMAL;
               end
               default: mode_in = PM_NORMAL;
            endcase
         end
         OP_SGR_STEP: begin
            sidx_in = sidx_ff + PIDX_W'(1);
            if (psgr == 16'd0) begin
               fg_in = COLOUR_DEFAULT; bg_in = COLOUR_DEFAULT; attr_in = 3'd0;
            end else if (psgr == 16'd1) begin
               attr_in = attr_ff | 3'b001;
            end else if (psgr == 16'd4) begin
               attr_in = attr_ff | 3'b010;
            end else if (psgr == 16'd7) begin
               attr_in = attr_ff | 3'b100;
            end else if (psgr >= 16'd30 && psgr <= 16'd37) begin
               fg_in = {2'b00, psgr[2:0] - 3'd6};
            end else if (psgr >= 16'd40 && psgr <= 16'd47) begin
               bg_in = {2'b00, psgr[2:0]};
            end else if (psgr >= 16'd90 && psgr <= 16'd97) begin
               fg_in = {2'b01, psgr[2:0] - 3'd2};
            end else if (psgr >= 16'd100 && psgr <= 16'd107) begin
               bg_in = {2'b01, psgr[2:0] - 3'd4};
            end
         end
         OP_CLAMP: x_in = cols_m1;
         default: ;
      endcase

      // result-producing steps: fields set to defaults, then relevant ones set
      if (cmd.op == OP_GLYPH || cmd.op == OP_DIRTY_HOME || cmd.op == OP_DIRTY ||
          cmd.op == OP_CLEAR || cmd.op == OP_SINGLE ||
          (cmd.op == OP_LINE_DOWN && !(y_ff < rows_m1))) begin
         ov_in = 1'b1;
         olast_in = cmd.last;
         orow_in = y_ff; ocol_in = 8'd0; ocp_in = 21'd0;
         ofg_in = 5'd0; obg_in = 5'd0; oattr_in = 3'd0; omode_in = 16'd0;
         ocmd_in = CMD_DIRTY;
         case (cmd.op)
            OP_GLYPH: begin
               ocmd_in = CMD_GLYPH; ocol_in = x_ff; ocp_in = cp_ff;
               ofg_in = fg_ff; obg_in = bg_ff; oattr_in = attr_ff;
            end
            OP_CLEAR: ocmd_in = CMD_CLEAR_LINE;
            OP_SINGLE: begin
               ocmd_in = single_cmd_ff; orow_in = single_row_ff;
               omode_in = (single_cmd_ff == CMD_SET_MODE ||
                           single_cmd_ff == CMD_RESET_MODE) ? single_mode_ff : 16'd0;
            end
            OP_LINE_DOWN: begin
               ocmd_in = CMD_SCROLL; orow_in = cfg.top; ocol_in = cfg.bottom;
            end
            default: ;
         endcase
      end

      case (cmd.op)
         OP_GLYPH: x_in = x_ff + 8'd1;
         OP_DIRTY_HOME, OP_CLEAR: x_in = 8'd0;
         OP_LINE_DOWN: if (y_ff < rows_m1) y_in = y_ff + 8'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= PM_NORMAL; prev_esc_ff <= 1'b0;
         x_ff <= 8'd0; y_ff <= 8'd0; sx_ff <= 8'd0; sy_ff <= 8'd0;
         for (int i = 0; i < MAX_PARAMS; i++) store_ff[i] <= 16'd0;
         total_ff <= '0; acc_ff <= 16'd0; priv_ff <= 1'b0;
         upend_ff <= 2'd0; uacc_ff <= 21'd0;
         fg_ff <= COLOUR_DEFAULT; bg_ff <= COLOUR_DEFAULT; attr_ff <= 3'd0;
         sidx_ff <= '0; ov_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in; prev_esc_ff <= prev_esc_in;
         x_ff <= x_in; y_ff <= y_in; sx_ff <= sx_in; sy_ff <= sy_in;
         store_ff <= store_in;
         total_ff <= total_in; acc_ff <= acc_in; priv_ff <= priv_in;
         upend_ff <= upend_in; uacc_ff <= uacc_in;
         fg_ff <= fg_in; bg_ff <= bg_in; attr_ff <= attr_in;
         sidx_ff <= sidx_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in; chunk_ff <= chunk_in; cp_ff <= cp_in;
      single_cmd_ff <= single_cmd_in; single_row_ff <= single_row_in;
      single_mode_ff <= single_mode_in;
      ocmd_ff <= ocmd_in; orow_ff <= orow_in; ocol_ff <= ocol_in; ocp_ff <= ocp_in;
      ofg_ff <= ofg_in; obg_ff <= obg_in; oattr_ff <= oattr_in;
      omode_ff <= omode_in; olast_ff <= olast_in;
   end

   assign status.cls      = cls;
   assign status.fits     = x_ff < cols_eff;
   assign status.x_past   = !(x_ff < cols_eff);
   assign status.wrap_en  = cfg.wrap;
   assign status.sgr_done = sidx_ff == lastidx;
   assign status.out_free = out_free;

   assign rsp_valid       = ov_ff;
   assign rsp_cmd         = ocmd_ff;
   assign rsp_row         = orow_ff;
   assign rsp_col         = ocol_ff;
   assign rsp_codepoint   = ocp_ff;
   assign rsp_fg_code     = ofg_ff;
   assign rsp_bg_code     = obg_ff;
   assign rsp_attr_bits   = oattr_ff;
   assign rsp_mode_number = omode_ff;
   assign rsp_last        = olast_ff;

endmodule

// ----- rtl/tep_ctrl.sv -----
// ----------------------------------------------------------------------------
// tep_ctrl
// Sequencer: takes a byte, decodes it, then steps through its grid commands.
// ----------------------------------------------------------------------------
module tep_ctrl import tep_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (status.cls)
               CLS_NEWLINE: state_in = ST_CLEAR;
               CLS_GLYPH:   state_in = ST_GLYPH;
               CLS_SINGLE:  state_in = ST_SINGLE;
               CLS_SGR:     state_in = ST_SGR;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_GLYPH: if (!status.fits || status.out_free) state_in = ST_WRAP;
         ST_WRAP: begin
            if (status.x_past && status.wrap_en) state_in = ST_DIRTY_HOME;
            else state_in = ST_DIRTY_LAST;
         end
         ST_DIRTY_HOME: if (status.out_free) state_in = ST_LD_WRAP;
         ST_LD_WRAP:    if (status.out_free) state_in = ST_DIRTY_MID;
         ST_DIRTY_MID:  if (status.out_free) state_in = ST_DIRTY_LAST;
         ST_DIRTY_LAST: if (status.out_free) state_in = ST_IDLE;
         ST_CLEAR:      if (status.out_free) state_in = ST_LD_NL;
         ST_LD_NL:      if (status.out_free) state_in = ST_DIRTY_LAST;
         ST_SINGLE:     if (status.out_free) state_in = ST_IDLE;
         ST_SGR:        if (status.sgr_done) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_IDLE;
      cmd.last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LATCH;
         end
         ST_DECODE: cmd.op = OP_DECODE;
         ST_GLYPH: if (status.fits && status.out_free) cmd.op = OP_GLYPH;
         ST_WRAP: if (status.x_past && !status.wrap_en) cmd.op = OP_CLAMP;
         ST_DIRTY_HOME: if (status.out_free) cmd.op = OP_DIRTY_HOME;
         ST_LD_WRAP, ST_LD_NL: if (status.out_free) cmd.op = OP_LINE_DOWN;
         ST_DIRTY_MID: if (status.out_free) cmd.op = OP_DIRTY;
         ST_DIRTY_LAST: begin
            cmd.last = 1'b1;
            if (status.out_free) cmd.op = OP_DIRTY;
         end
         ST_CLEAR: if (status.out_free) cmd.op = OP_CLEAR;
         ST_SINGLE: begin
            cmd.last = 1'b1;
            if (status.out_free) cmd.op = OP_SINGLE;
         end
         ST_SGR: cmd.op = OP_SGR_STEP;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/terminal_escape_parser_top.sv -----
// ----------------------------------------------------------------------------
// terminal_escape_parser_top
// Byte-serial VT100/ANSI parser producing grid commands.
// ----------------------------------------------------------------------------
// One terminal byte is taken per transfer on req and turned into zero to five
// grid commands on rsp, the final one flagged by last. Bytes are handled one
// at a time, set by the sequencer in tep_ctrl. Every byte is first taken, then
// decoded. Then it walks the steps of its command sequence: write, edge check
// and dirty for a glyph that does not wrap; write, edge check, dirty, line
// down, dirty and dirty for a glyph that wraps; clear line, line down and
// dirty for a newline; and a single step for a clear or mode command. A
// line-down step is taken even when no scroll results. No glyph is written
// while the cursor is past the edge. An SGR sequence with a non-zero first
// parameter adds a parameter-decode step that walks its parameters (up to 16)
// one by one. A finished command waits in the output register while the
// sequencer goes on. Every step that emits a command stalls while that
// register still holds one not yet taken.
// The csr port sets rows, columns, scroll region and wrap; write it only while
// no byte is in flight.
// ----------------------------------------------------------------------------
module terminal_escape_parser_top import tep_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tep_req_if.sink    req,
   tep_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // configuration registers, reset to a 24 x 80 screen with wrap on
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS:   cfg_in.rows   = csr_wdata;
            CSR_COLS:   cfg_in.cols   = csr_wdata;
            CSR_TOP:    cfg_in.top    = csr_wdata;
            CSR_BOTTOM: cfg_in.bottom = csr_wdata;
            CSR_WRAP:   cfg_in.wrap   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows   <= 8'd24;
         cfg_ff.cols   <= 8'd80;
         cfg_ff.top    <= 8'd0;
         cfg_ff.bottom <= 8'd23;
         cfg_ff.wrap   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   tep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parse state, cursor and output register
   tep_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .in_byte         (req.in_byte),
      .chunk_last      (req.chunk_last),
      .rsp_ready       (rsp.ready),
      .status          (status),
      .rsp_valid       (rsp.valid),
      .rsp_cmd         (rsp.cmd),
      .rsp_row         (rsp.row),
      .rsp_col         (rsp.col),
      .rsp_codepoint   (rsp.codepoint),
      .rsp_fg_code     (rsp.fg_code),
      .rsp_bg_code     (rsp.bg_code),
      .rsp_attr_bits   (rsp.attr_bits),
      .rsp_mode_number (rsp.mode_number),
      .rsp_last        (rsp.last)
   );

endmodule
